@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the expression evaluator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TSEE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tsee assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define TSEE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tsee assertion failed");

`endif

@@ rtl/tsee_pkg.sv @@
// ----------------------------------------------------------------------------
// tsee_pkg
// Types, constants and helpers shared by the expression evaluator modules.
// ----------------------------------------------------------------------------
package tsee_pkg;

  // Sizes
  localparam int VALUE_DEPTH = 64;
  localparam int OP_DEPTH    = 64;
  localparam int DATA_W      = 32;
  localparam int CH_W        = 8;
  localparam int ST_W        = 2;
  localparam int DEPTH_W     = 7;
  localparam int VADDR_W     = $clog2(VALUE_DEPTH);
  localparam int VCNT_W      = $clog2(VALUE_DEPTH + 1);
  localparam int OADDR_W     = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
  localparam int OCNT_W      = $clog2(OP_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;
  localparam int IN_PAD_W    = IN_TDATA_W - 1 - CH_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - ST_W - DEPTH_W;

  // Characters
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CH_W-1:0] CH_PCT    = 8'h25;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;

  localparam logic [DATA_W-1:0] DEC_RADIX = 32'd10;

  typedef enum logic [ST_W-1:0] {
    ST_OK, ST_UNDER, ST_OVER, ST_DIVZERO
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD
  } opcode_t;

  typedef struct packed {
    logic    valid;
    opcode_t code;
  } op_dec_t;

  // How a combine result goes back on the value stack
  typedef enum logic [1:0] {
    CM_PAREN, CM_FINAL_OP, CM_FINAL_ADD
  } cmode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHAR, S_PRD, S_PEXE, S_PDIV, S_FLUSH, S_FRD, S_FEXE, S_FDIV, S_OUT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic   load;
    logic   char_step;
    logic   flush;
    logic   rd;
    logic   under;
    logic   commit;
    cmode_t mode;
    logic   div_start;
    logic   load_out;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic eoe;
    logic is_digit;
    logic is_paren;
    logic paren_ok;
    logic v_empty;
    logic v_one;
    logic op_avail;
    logic div_op;
    logic div_zero;
    logic div_done;
  } dp_sts_t;

  function automatic op_dec_t op_decode(input logic [CH_W-1:0] c);
    op_dec_t d;
    d.valid = 1'b1;
    case (c)
      CH_PLUS:  d.code = OP_ADD;
      CH_MINUS: d.code = OP_SUB;
      CH_STAR:  d.code = OP_MUL;
      CH_SLASH: d.code = OP_DIV;
      CH_PCT:   d.code = OP_MOD;
      default: begin
        d.valid = 1'b0;
        d.code  = OP_ADD;
      end
    endcase
    return d;
  endfunction

endpackage

@@ rtl/tsee_div.sv @@
// ----------------------------------------------------------------------------
// tsee_div
// Signed 32-bit divider, radix 2 restoring, one quotient bit per cycle.
// Truncates toward zero; remainder takes the dividend's sign.
// ----------------------------------------------------------------------------
module tsee_div import tsee_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient,
  output logic [DATA_W-1:0] remainder
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    q_r, q_nxt;
  logic [DATA_W-1:0]    dsr_r, dsr_nxt;
  logic                 qneg_r, qneg_nxt;
  logic                 rneg_r, rneg_nxt;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;

  // One restoring step
  assign shifted = {rem_r, q_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dsr_nxt  = dsr_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DATA_W - 1);
      rem_nxt  = '0;
      q_nxt    = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dsr_nxt  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      qneg_nxt = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      rneg_nxt = dividend[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
        q_nxt   = {q_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DATA_W-1:0];
        q_nxt   = {q_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    dsr_r  <= dsr_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  // Sign fix on the magnitudes
  assign done      = done_r;
  assign quotient  = qneg_r ? (~q_r + 1'b1) : q_r;
  assign remainder = rneg_r ? (~rem_r + 1'b1) : rem_r;

endmodule

@@ rtl/tsee_datapath.sv @@
// ----------------------------------------------------------------------------
// tsee_datapath
// Value and operator stacks, digit accumulator, combine unit, sticky error
// and the output register.
// ----------------------------------------------------------------------------
module tsee_datapath import tsee_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               in_clear,
  input  logic [CH_W-1:0]    in_ch,
  input  logic               in_eoe,
  output logic [DATA_W-1:0]  out_value,
  output status_t            out_status,
  output logic [DEPTH_W-1:0] out_depth
);

  // Stack memories
  logic [DATA_W-1:0] vmem [VALUE_DEPTH];
  opcode_t           omem [OP_DEPTH];

  logic [CH_W-1:0]    ch_r;
  logic               eoe_r;
  logic [DATA_W-1:0]  top_r, top_nxt;
  logic [VCNT_W-1:0]  vcnt_r, vcnt_nxt;
  logic [OCNT_W-1:0]  opcnt_r, opcnt_nxt;
  logic [DATA_W-1:0]  accum_r, accum_nxt;
  logic               in_num_r, in_num_nxt;
  status_t            err_r, err_nxt;
  logic [DATA_W-1:0]  vrd_r;
  opcode_t            ord_r;
  logic [DATA_W-1:0]  out_value_r;
  status_t            out_status_r;
  logic [DEPTH_W-1:0] out_depth_r;

  logic               vwe;
  logic [VADDR_W-1:0] vwaddr;
  logic [DATA_W-1:0]  vwdata;
  logic               owe;
  logic [OADDR_W-1:0] owaddr;
  logic [VCNT_W-1:0]  vcnt_m1, vcnt_m2;
  logic [OCNT_W-1:0]  opcnt_m1;
  op_dec_t            dec;
  logic               is_digit;
  logic [DATA_W-1:0]  digit;
  logic [DATA_W-1:0]  accum_base;
  logic               div_op;
  logic               zero_hit;
  logic [DATA_W-1:0]  result;
  logic               div_done;
  logic [DATA_W-1:0]  div_q, div_r;

  assign vcnt_m1  = vcnt_r - VCNT_W'(1);
  assign vcnt_m2  = vcnt_r - VCNT_W'(2);
  assign opcnt_m1 = opcnt_r - OCNT_W'(1);

  // Character decode
  assign dec        = op_decode(ch_r);
  assign is_digit   = ch_r inside {[CH_ZERO:CH_NINE]};
  assign digit      = {{(DATA_W-CH_W){1'b0}}, ch_r - CH_ZERO};
  assign accum_base = in_num_r ? accum_r : '0;

  // Combine unit: left operand from memory read, right operand is the top
  assign div_op   = (ord_r == OP_DIV) || (ord_r == OP_MOD);
  assign zero_hit = (cmd.mode != CM_FINAL_ADD) && div_op && (top_r == '0);

  always_comb begin
    if (cmd.mode == CM_FINAL_ADD) begin
      result = vrd_r + top_r;
    end else begin
      case (ord_r)
        OP_ADD:  result = vrd_r + top_r;
        OP_SUB:  result = vrd_r - top_r;
        OP_MUL:  result = vrd_r * top_r;
        OP_DIV:  result = (top_r == '0) ? '0 : div_q;
        OP_MOD:  result = (top_r == '0) ? '0 : div_r;
        default: result = '0;
      endcase
    end
  end

  tsee_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (vrd_r),
    .divisor   (top_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Next-state of the stack control
  always_comb begin
    vcnt_nxt   = vcnt_r;
    opcnt_nxt  = opcnt_r;
    accum_nxt  = accum_r;
    in_num_nxt = in_num_r;
    err_nxt    = err_r;
    top_nxt    = top_r;
    vwe        = 1'b0;
    vwaddr     = vcnt_r[VADDR_W-1:0];
    vwdata     = accum_r;
    owe        = 1'b0;
    owaddr     = opcnt_r[OADDR_W-1:0];

    if (cmd.load && in_clear) begin
      vcnt_nxt   = '0;
      opcnt_nxt  = '0;
      accum_nxt  = '0;
      in_num_nxt = 1'b0;
      err_nxt    = ST_OK;
    end

    // Digit accumulate
    if (cmd.char_step && is_digit) begin
      accum_nxt  = accum_base * DEC_RADIX + digit;
      in_num_nxt = 1'b1;
    end

    // Push a pending number
    if (((cmd.char_step && !is_digit) || cmd.flush) && in_num_r) begin
      in_num_nxt = 1'b0;
      accum_nxt  = '0;
      if (vcnt_r == VCNT_W'(VALUE_DEPTH)) begin
        if (err_nxt == ST_OK) err_nxt = ST_OVER;
      end else begin
        vwe      = 1'b1;
        top_nxt  = accum_r;
        vcnt_nxt = vcnt_r + VCNT_W'(1);
      end
    end

    // Operator push
    if (cmd.char_step && !is_digit && dec.valid) begin
      if (opcnt_r == OCNT_W'(OP_DEPTH)) begin
        if (err_nxt == ST_OK) err_nxt = ST_OVER;
      end else begin
        owe       = 1'b1;
        opcnt_nxt = opcnt_r + OCNT_W'(1);
      end
    end

    if (cmd.under) begin
      if (err_nxt == ST_OK) err_nxt = ST_UNDER;
    end

    // Write back a combine result
    if (cmd.commit) begin
      vwe     = 1'b1;
      vwdata  = result;
      top_nxt = result;
      if (zero_hit && err_nxt == ST_OK) err_nxt = ST_DIVZERO;
      case (cmd.mode)
        CM_PAREN: begin
          vwaddr    = vcnt_m2[VADDR_W-1:0];
          vcnt_nxt  = vcnt_m1;
          opcnt_nxt = opcnt_m1;
        end
        CM_FINAL_OP: begin
          vwaddr    = vcnt_m1[VADDR_W-1:0];
          opcnt_nxt = opcnt_m1;
        end
        default: begin
          vwaddr   = vcnt_m2[VADDR_W-1:0];
          vcnt_nxt = vcnt_m1;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r   <= '0;
      opcnt_r  <= '0;
      accum_r  <= '0;
      in_num_r <= 1'b0;
      err_r    <= ST_OK;
    end else begin
      vcnt_r   <= vcnt_nxt;
      opcnt_r  <= opcnt_nxt;
      accum_r  <= accum_nxt;
      in_num_r <= in_num_nxt;
      err_r    <= err_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (cmd.load) begin
      ch_r  <= in_ch;
      eoe_r <= in_eoe;
    end
    if (cmd.load_out) begin
      out_value_r  <= (vcnt_r != '0) ? top_r : '0;
      out_status_r <= err_r;
      out_depth_r  <= DEPTH_W'(vcnt_r);
    end
  end

  // Stack memories, registered reads
  always_ff @(posedge clk) begin
    if (vwe) vmem[vwaddr] <= vwdata;
    if (owe) omem[owaddr] <= dec.code;
    if (cmd.rd) begin
      vrd_r <= vmem[vcnt_m2[VADDR_W-1:0]];
      ord_r <= omem[opcnt_m1[OADDR_W-1:0]];
    end
  end

  // Status to controller
  always_comb begin
    sts.eoe      = eoe_r;
    sts.is_digit = is_digit;
    sts.is_paren = (ch_r == CH_RPAREN);
    sts.paren_ok = (vcnt_r >= VCNT_W'(2)) && (opcnt_r != '0);
    sts.v_empty  = (vcnt_r == '0);
    sts.v_one    = (vcnt_r == VCNT_W'(1));
    sts.op_avail = (opcnt_r != '0);
    sts.div_op   = div_op;
    sts.div_zero = (top_r == '0);
    sts.div_done = div_done;
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_depth  = out_depth_r;

endmodule

@@ rtl/tsee_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsee_ctrl
// Sequencer for the expression evaluator: steps one character through
// decode, stack access, combine and result output.
// ----------------------------------------------------------------------------
module tsee_ctrl import tsee_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   run_div;
  logic   fin_div;
  logic   out_free;
  logic   done_state;

  assign run_div  = sts.div_op && !sts.div_zero;
  assign fin_div  = sts.op_avail && run_div;
  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt  = state_r;
    done_state = sts.eoe;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_CHAR;
      S_CHAR: begin
        if (!sts.is_digit && sts.is_paren) state_nxt = S_PRD;
        else state_nxt = done_state ? S_FLUSH : S_IDLE;
      end
      S_PRD: begin
        if (sts.paren_ok) state_nxt = S_PEXE;
        else state_nxt = done_state ? S_FLUSH : S_IDLE;
      end
      S_PEXE: begin
        if (run_div) state_nxt = S_PDIV;
        else state_nxt = done_state ? S_FLUSH : S_IDLE;
      end
      S_PDIV: begin
        if (sts.div_done) state_nxt = done_state ? S_FLUSH : S_IDLE;
      end
      S_FLUSH: state_nxt = S_FRD;
      S_FRD: begin
        if (sts.v_empty || sts.v_one) state_nxt = S_OUT;
        else state_nxt = S_FEXE;
      end
      S_FEXE:  state_nxt = fin_div ? S_FDIV : S_OUT;
      S_FDIV:  if (sts.div_done) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.mode      = CM_PAREN;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_CHAR:  cmd.char_step = 1'b1;
      S_PRD: begin
        cmd.rd    = sts.paren_ok;
        cmd.under = !sts.paren_ok;
      end
      S_PEXE: begin
        cmd.div_start = run_div;
        cmd.commit    = !run_div;
      end
      S_PDIV:  cmd.commit = sts.div_done;
      S_FLUSH: cmd.flush = 1'b1;
      S_FRD: begin
        cmd.rd    = !(sts.v_empty || sts.v_one);
        cmd.under = sts.v_empty;
      end
      S_FEXE: begin
        cmd.mode      = sts.op_avail ? CM_FINAL_OP : CM_FINAL_ADD;
        cmd.div_start = fin_div;
        cmd.commit    = !fin_div;
      end
      S_FDIV: begin
        cmd.mode   = CM_FINAL_OP;
        cmd.commit = sts.div_done;
      end
      S_OUT:   cmd.load_out = out_free;
      default: cmd.load_out = 1'b0;
    endcase
  end

  // Output valid flag
  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ rtl/two_stack_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// two_stack_expression_evaluator
// Infix expression evaluator with a value stack and an operator stack.
//
// Input stream: one ASCII character per transaction. in_tdata[0] is the
// clear flag (empties both stacks and the sticky error first), in_tdata[8:1]
// the character; in_tlast marks the last character of an expression.
// Output stream: one transaction per expression, after the in_tlast item:
// value, sticky status and the depth left on the value stack.
// Items are processed one at a time by a sequencer: a plain character is
// accepted, then decoded; ')' adds an operand read and a combine (no combine
// with too few operands), and '/' or '%' also runs the radix-2 divider. The
// end item adds a flush, an operand read, a combine and an output load (no
// combine with fewer than two values), plus the divider on a final divide.
// Reset (rst_n low, synchronous) empties both stacks, drops any partial
// number and clears the error; no clearing pass is needed. A result waits
// in the output register while the receiver stalls; the next characters are
// still taken, and only the next end item waits for the register to drain.
// ----------------------------------------------------------------------------
module two_stack_expression_evaluator import tsee_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] clear, [8:1] ch, rest zero
  input  logic                   in_tlast,   // end_of_expr
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [31:0] value, [33:32] status,
                                             // [40:34] depth, rest zero
);

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [DATA_W-1:0]  out_value;
  status_t            out_status;
  logic [DEPTH_W-1:0] out_depth;

  tsee_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tsee_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_clear   (in_tdata[0]),
    .in_ch      (in_tdata[CH_W:1]),
    .in_eoe     (in_tlast),
    .out_value  (out_value),
    .out_status (out_status),
    .out_depth  (out_depth)
  );

  // Pack the result transaction
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_depth, out_status, out_value};

endmodule

@@ rtl/tsee_checker.sv @@
// ----------------------------------------------------------------------------
// tsee_checker
// Port-level checks for the expression evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsee_checker import tsee_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // Stalled result holds
  `TSEE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `TSEE_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

  // One character in flight at a time
  `TSEE_ASSERT_NEXT(a_one_item, clk, rst_n, in_acc, !in_tready)

  // Only an end item produces a result
  `TSEE_ASSERT_NEXT(a_no_early_out, clk, rst_n, in_acc && !in_tlast, !$rose(out_tvalid))

  // Depth never exceeds the stack size
  `TSEE_ASSERT_SAME(a_depth_bound, clk, rst_n, out_tvalid,
    out_tdata[40:34] <= DEPTH_W'(VALUE_DEPTH))

endmodule

bind two_stack_expression_evaluator tsee_checker u_tsee_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-stack expression evaluator. Characters go
// in one transaction at a time; an in-bench model of both stacks predicts
// every end-of-expression answer, and a scoreboard compares each output
// transaction field by field. A short directed part covers each operator,
// divide by zero and underflow. Random expressions follow: mostly well-formed
// nested ones, plus broken token runs, noise bytes and stack overflow bursts.
// Both sides idle at random, and the output side holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module tb;
  import tsee_pkg::*;

  localparam int          ITEMS_TARGET = 1150;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          HOLD_CYCLES  = 800;
  localparam int          HOLD_AT      = 12;

  // One expected answer
  typedef struct {
    logic signed [DATA_W-1:0]  value;
    status_t                   status;
    logic        [DEPTH_W-1:0] depth;
  } answer_t;

  // Output word layout, lowest field last
  typedef struct packed {
    logic        [OUT_PAD_W-1:0] pad;
    logic        [DEPTH_W-1:0]   depth;
    logic        [ST_W-1:0]      status;
    logic signed [DATA_W-1:0]    value;
  } out_word_t;

  // One character transaction to send
  typedef struct {
    bit              clr;
    logic [CH_W-1:0] ch;
    bit              last;
  } char_item_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks both stacks and queues the answers they imply
  // --------------------------------------------------------------------------
  class eval_scoreboard;
    logic [DATA_W-1:0] vstack [VALUE_DEPTH];
    opcode_t           ostack [OP_DEPTH];
    int unsigned       vcount;
    int unsigned       ocount;
    logic [DATA_W-1:0] accum;
    bit                building;
    status_t           sticky;
    answer_t           expected_answers [$];
    int unsigned       errors;
    int unsigned       answers;
    int unsigned       status_seen [4];

    function new();
      vcount   = 0;
      ocount   = 0;
      accum    = '0;
      building = 1'b0;
      sticky   = ST_OK;
      errors   = 0;
      answers  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // first error since the last clear wins
    function void flag_error(status_t code);
      if (sticky == ST_OK) sticky = code;
    endfunction

    function void push_value(logic [DATA_W-1:0] v);
      if (vcount >= VALUE_DEPTH) begin
        flag_error(ST_OVER);
        return;
      end
      vstack[vcount] = v;
      vcount++;
    endfunction

    function bit op_of(logic [CH_W-1:0] c, output opcode_t op);
      op = OP_ADD;
      case (c)
        CH_PLUS:  op = OP_ADD;
        CH_MINUS: op = OP_SUB;
        CH_STAR:  op = OP_MUL;
        CH_SLASH: op = OP_DIV;
        CH_PCT:   op = OP_MOD;
        default:  return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // a op b; division truncates toward zero
    function logic [DATA_W-1:0] apply_op(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                         opcode_t op);
      logic signed [DATA_W-1:0] sa;
      logic signed [DATA_W-1:0] sb;
      logic signed [DATA_W-1:0] q;
      sa = a;
      sb = b;
      case (op)
        OP_ADD: return a + b;
        OP_SUB: return a - b;
        OP_MUL: return a * b;
        OP_DIV, OP_MOD: begin
          if (b == '0) begin
            flag_error(ST_DIVZERO);
            return '0;
          end
          // most negative over minus one wraps
          if (a == {1'b1, {(DATA_W-1){1'b0}}} && b == '1)
            return (op == OP_DIV) ? a : '0;
          if (op == OP_DIV) q = sa / sb;
          else q = sa % sb;
          return q;
        end
        default: return '0;
      endcase
    endfunction

    function void flush_number();
      if (building) begin
        push_value(accum);
        building = 1'b0;
        accum    = '0;
      end
    endfunction

    function void close_paren();
      logic [DATA_W-1:0] right;
      logic [DATA_W-1:0] left;
      opcode_t           op;
      if (vcount < 2 || ocount < 1) begin
        flag_error(ST_UNDER);
        return;
      end
      right  = vstack[vcount-1];
      left   = vstack[vcount-2];
      op     = ostack[ocount-1];
      vcount = vcount - 2;
      ocount = ocount - 1;
      push_value(apply_op(left, right, op));
    endfunction

    // the second value stays put when an operator is waiting
    function void final_combine();
      logic [DATA_W-1:0] t;
      opcode_t           op;
      if (vcount == 0) begin
        flag_error(ST_UNDER);
        return;
      end
      t = vstack[vcount-1];
      vcount--;
      if (vcount > 0) begin
        if (ocount > 0) begin
          op = ostack[ocount-1];
          ocount--;
          t = apply_op(vstack[vcount-1], t, op);
        end else begin
          t = t + vstack[vcount-1];
          vcount--;
        end
      end
      push_value(t);
    endfunction

    // Accepted input transaction
    function void take_char(bit clr, logic [CH_W-1:0] c, bit last);
      opcode_t op;
      answer_t ans;
      if (clr) begin
        vcount   = 0;
        ocount   = 0;
        accum    = '0;
        building = 1'b0;
        sticky   = ST_OK;
      end
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (!building) begin
          accum    = '0;
          building = 1'b1;
        end
        accum = accum * DEC_RADIX + DATA_W'(c - CH_ZERO);
      end else begin
        flush_number();
        if (op_of(c, op)) begin
          if (ocount >= OP_DEPTH) flag_error(ST_OVER);
          else begin
            ostack[ocount] = op;
            ocount++;
          end
        end else if (c == CH_RPAREN) begin
          close_paren();
        end
      end
      if (!last) return;
      flush_number();
      final_combine();
      ans.value  = (vcount > 0) ? vstack[vcount-1] : '0;
      ans.status = sticky;
      ans.depth  = DEPTH_W'(vcount);
      expected_answers.push_back(ans);
    endfunction

    // Accepted output transaction
    function void check_answer(logic [OUT_TDATA_W-1:0] d);
      out_word_t w;
      answer_t   exp_a;
      w = out_word_t'(d);
      if (expected_answers.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: expected nothing, actual %h", $time, d);
        return;
      end
      exp_a = expected_answers.pop_front();
      answers++;
      status_seen[exp_a.status]++;
      if (w.value !== exp_a.value) begin
        errors++;
        $display("%0t: value mismatch: expected %0d, actual %0d",
                 $time, exp_a.value, w.value);
      end
      if (w.status !== exp_a.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp_a.status, w.status);
      end
      if (w.depth !== exp_a.depth) begin
        errors++;
        $display("%0t: depth mismatch: expected %0d, actual %0d",
                 $time, exp_a.depth, w.depth);
      end
      if (w.pad !== '0) begin
        errors++;
        $display("%0t: padding mismatch: expected 0, actual %h", $time, w.pad);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  eval_scoreboard eval_sb;
  char_item_t     expr_chars [$];
  bit             no_gaps;
  int unsigned    items_sent;
  int unsigned    active_items;
  int unsigned    answers_taken;
  int unsigned    cycle_count;

  two_stack_expression_evaluator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Idle lengths: mostly none or short, a few long
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Expression text builders
  // --------------------------------------------------------------------------
  function automatic void put_item(bit clr, logic [CH_W-1:0] c, bit last);
    char_item_t item;
    item.clr  = clr;
    item.ch   = c;
    item.last = last;
    expr_chars.push_back(item);
  endfunction

  function automatic void put_char(logic [CH_W-1:0] c);
    put_item(1'b0, c, 1'b0);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic void put_digits(int n);
    repeat (n) put_char(CH_ZERO + CH_W'($urandom_range(0, 9)));
  endfunction

  // short numbers mostly; long runs wrap past 32 bits
  function automatic void put_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) put_char(CH_ZERO);
    else if (r < 55) put_digits($urandom_range(1, 2));
    else if (r < 85) put_digits($urandom_range(3, 12));
    else begin
      case ($urandom_range(0, 2))
        0:       put_text("2147483648");
        1:       put_text("4294967295");
        default: put_text("2147483647");
      endcase
    end
  endfunction

  function automatic void put_op();
    case ($urandom_range(0, 4))
      0:       put_char(CH_PLUS);
      1:       put_char(CH_MINUS);
      2:       put_char(CH_STAR);
      3:       put_char(CH_SLASH);
      default: put_char(CH_PCT);
    endcase
  endfunction

  // ignored characters scattered between tokens
  function automatic void put_filler();
    if ($urandom_range(0, 7) != 0) return;
    case ($urandom_range(0, 2))
      0:       put_char(" ");
      1:       put_char("(");
      default: put_char(8'h80 | CH_W'($urandom_range(0, 127)));
    endcase
  endfunction

  function automatic void put_term(int lvl);
    if (lvl == 0 || $urandom_range(0, 2) == 0) begin
      put_number();
    end else begin
      put_char("(");
      put_term(lvl - 1);
      put_filler();
      put_op();
      put_filler();
      put_term(lvl - 1);
      put_char(CH_RPAREN);
    end
  endfunction

  function automatic bit is_active(logic [CH_W-1:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
           c == CH_STAR || c == CH_SLASH || c == CH_PCT || c == CH_RPAREN;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task automatic send_char(input bit clr, input logic [CH_W-1:0] c, input bit last);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{IN_PAD_W{1'b0}}, c, clr};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    eval_sb.take_char(clr, c, last);
    items_sent++;
    if (clr || last || is_active(c)) active_items++;
  endtask

  // sends the built text; optional clear on the first, end flag on the last
  task automatic send_expr(input bit start_clear, input bit end_flag);
    int  n;
    bit  clr;
    bit  last;
    n = expr_chars.size();
    for (int i = 0; i < n; i++) begin
      clr  = expr_chars[i].clr || (i == 0 && start_clear) || ($urandom_range(0, 199) == 0);
      last = expr_chars[i].last || (i == n - 1 && end_flag);
      send_char(clr, expr_chars[i].ch, last);
    end
    expr_chars.delete();
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls, ready-only windows, one long hold-off
  // --------------------------------------------------------------------------
  initial begin : answer_sink
    int stall_left;
    int ready_run;
    bit held_off;
    stall_left = 0;
    ready_run  = 0;
    held_off   = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        eval_sb.check_answer(out_tdata);
        answers_taken++;
      end
      if (answers_taken == HOLD_AT && !held_off) begin
        held_off   = 1'b1;
        stall_left = HOLD_CYCLES;
        ready_run  = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (ready_run > 0) begin
        ready_run--;
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        ready_run = $urandom_range(50, 200);
        out_tready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cycle limit
  // --------------------------------------------------------------------------
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int expr_idx;
    int r;
    bit start_clear;
    bit end_flag;
    eval_sb       = new();
    items_sent    = 0;
    active_items  = 0;
    answers_taken = 0;
    no_gaps       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: each operator, paren combine, ignored bytes, error cases
    put_item(1'b1, "4", 1'b0);   put_item(1'b0, CH_MINUS, 1'b0); put_item(1'b0, "9", 1'b1);
    put_item(1'b1, "7", 1'b0);   put_item(1'b0, CH_PCT, 1'b0);   put_item(1'b0, "3", 1'b0);
    put_item(1'b0, CH_RPAREN, 1'b0);
    put_item(1'b0, 8'hFF, 1'b1);
    // divide by zero, then stays sticky through the next expression
    put_item(1'b1, "5", 1'b0);   put_item(1'b0, CH_SLASH, 1'b0); put_item(1'b0, "0", 1'b1);
    put_item(1'b0, "8", 1'b0);   put_item(1'b0, 8'h00, 1'b1);
    // too few operands at ')' and an empty stack at the end
    put_item(1'b1, CH_RPAREN, 1'b1);
    put_item(1'b1, "6", 1'b0);   put_item(1'b0, CH_STAR, 1'b0);  put_item(1'b0, "7", 1'b1);
    put_item(1'b0, "1", 1'b0);   put_item(1'b0, CH_PLUS, 1'b0);  put_item(1'b0, "2", 1'b1);
    send_expr(1'b0, 1'b0);

    // Random expressions
    expr_idx = 0;
    while (items_sent < ITEMS_TARGET) begin
      no_gaps     = ($urandom_range(0, 3) == 0);
      start_clear = ($urandom_range(0, 3) == 0);
      end_flag    = 1'b1;
      case (expr_idx)
        // value stack overflow
        2: begin
          repeat ($urandom_range(66, 70)) begin
            put_number();
            put_char(" ");
          end
        end
        // operator stack overflow
        5: begin
          put_number();
          repeat ($urandom_range(65, 68)) put_op();
          put_number();
        end
        // most negative over minus one, in parens and at the final combine
        8: begin
          start_clear = 1'b1;
          put_text("(2147483648/4294967295)");
        end
        9: begin
          start_clear = 1'b1;
          put_text("2147483648%4294967295");
        end
        default: begin
          r = $urandom_range(0, 99);
          if (r < 75) begin
            put_filler();
            put_term($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 7) begin
              put_filler();
              put_op();
              put_term($urandom_range(0, 2));
            end
          end else if (r < 88) begin
            // broken token runs
            repeat ($urandom_range(1, 12)) begin
              case ($urandom_range(0, 4))
                0:       put_number();
                1:       put_op();
                2:       put_char(CH_RPAREN);
                3:       put_char("(");
                default: put_char(" ");
              endcase
            end
          end else begin
            repeat ($urandom_range(1, 8)) put_char(CH_W'($urandom_range(0, 255)));
            end_flag = $urandom_range(0, 1);
          end
        end
      endcase
      send_expr(start_clear, end_flag);
      expr_idx++;
    end
    in_tvalid <= 1'b0;

    // drain, then let any trailing work settle
    while (eval_sb.expected_answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d characters (%0d doing work), checked %0d answers.",
             items_sent, active_items, eval_sb.answers);
    $display("Answer status: ok %0d, underflow %0d, overflow %0d, divide by zero %0d.",
             eval_sb.status_seen[ST_OK], eval_sb.status_seen[ST_UNDER],
             eval_sb.status_seen[ST_OVER], eval_sb.status_seen[ST_DIVZERO]);
    if (eval_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
